/* rtl/akar_pkg.sv */
package akar_pkg;

  // Default number of direction lanes. Only the first MASK_W lanes can ever
  // become active, because the input mask carries MASK_W bits.
  localparam int NUM_DIRECTIONS_DEF = 4;
  localparam int MASK_W             = 4;
  localparam int TIME_W             = 32;
  localparam int DELAY_W            = 16;
  localparam int CFG_INDEX_W        = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_DELAY = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_REST_DELAY  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_DELAY   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_TIME  = 2'd3;

  // Register values after reset.
  localparam logic [DELAY_W-1:0] FIRST_DELAY_RST = 16'd420;
  localparam logic [DELAY_W-1:0] REST_DELAY_RST  = 16'd210;
  localparam logic [DELAY_W-1:0] MIN_DELAY_RST   = 16'd50;
  localparam logic [DELAY_W-1:0] ACCEL_TIME_RST  = 16'd1500;

  typedef enum logic [1:0] {
    KIND_RELEASE = 2'd0,
    KIND_PRESS   = 2'd1,
    KIND_REPEAT  = 2'd2
  } event_kind_t;

  typedef struct packed {
    logic [DELAY_W-1:0] first_delay_ms;
    logic [DELAY_W-1:0] rest_delay_ms;
    logic [DELAY_W-1:0] min_delay_ms;
    logic [DELAY_W-1:0] accel_time_ms;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic [MASK_W-1:0] active_mask;
  } in_item_t;

  typedef struct packed {
    logic [1:0] direction;
    logic [1:0] event_kind;
    logic       last_event;
  } out_item_t;

  // Controller to lanes.
  typedef struct packed {
    logic start;
    logic ack;
  } lane_cmd_t;

  // Lane to controller and merging stage.
  typedef struct packed {
    logic        done;
    logic        emit;
    event_kind_t kind;
  } lane_stat_t;

  typedef enum logic [2:0] {
    L_IDLE,
    L_MUL,
    L_DIV,
    L_FIN,
    L_DONE
  } lane_state_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_START,
    T_RUN,
    T_EMIT
  } top_state_t;

endpackage

/* rtl/akar_lane.sv */
module akar_lane (
  input  logic                                clk,
  input  logic                                rst,
  input  akar_pkg::lane_cmd_t                 cmd,
  input  akar_pkg::cfg_t                      cfg,
  input  logic [akar_pkg::TIME_W-1:0]         now_ms,
  input  logic                                active,
  output akar_pkg::lane_stat_t                stat
);
  import akar_pkg::*;

  localparam int DIV_STEPS = 2 * DELAY_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  lane_state_t state, state_next;

  logic                 held;
  logic [TIME_W-1:0]    press_time;
  logic [TIME_W-1:0]    next_rep;
  logic                 emit;
  event_kind_t          kind;
  logic [CNT_W-1:0]     cnt;

  logic [DELAY_W-1:0]   prog_q;
  logic [DELAY_W-1:0]   diff_q;
  logic [DIV_STEPS-1:0] dvd;
  logic [DELAY_W:0]     rem;

  logic                 due;
  logic                 no_accel;
  logic                 need_div;
  logic [TIME_W-1:0]    held_ms;
  logic [DELAY_W-1:0]   prog;
  logic [DELAY_W:0]     shifted;
  logic                 ge;
  logic [DELAY_W-1:0]   gap;

  assign due      = now_ms >= next_rep;
  assign no_accel = (cfg.accel_time_ms == '0) || (cfg.rest_delay_ms <= cfg.min_delay_ms);
  assign need_div = active && held && due && !no_accel;
  assign held_ms  = now_ms - press_time;
  assign prog     = (held_ms < {{(TIME_W-DELAY_W){1'b0}}, cfg.accel_time_ms}) ?
                    held_ms[DELAY_W-1:0] : cfg.accel_time_ms;

  // One quotient bit per cycle. The remainder stays below the divisor, so
  // its top bit is always clear before the shift.
  assign shifted = {rem[DELAY_W-1:0], dvd[DIV_STEPS-1]};
  assign ge      = shifted >= {1'b0, cfg.accel_time_ms};
  assign gap     = cfg.rest_delay_ms - dvd[DELAY_W-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      L_IDLE: begin
        if (cmd.start) begin
          state_next = need_div ? L_MUL : L_DONE;
        end
      end
      L_MUL:  state_next = L_DIV;
      L_DIV: begin
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = L_FIN;
        end
      end
      L_FIN:  state_next = L_DONE;
      L_DONE: begin
        if (cmd.ack) begin
          state_next = L_IDLE;
        end
      end
      default: state_next = L_IDLE;
    endcase
  end

  always_comb begin
    stat.done = (state == L_DONE);
    stat.emit = emit;
    stat.kind = kind;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= L_IDLE;
      held       <= 1'b0;
      press_time <= '0;
      next_rep   <= '0;
      emit       <= 1'b0;
      cnt        <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        L_IDLE: begin
          if (cmd.start) begin
            if (!active) begin
              emit       <= held;
              held       <= 1'b0;
              press_time <= '0;
              next_rep   <= '0;
            end else if (!held) begin
              emit       <= 1'b1;
              held       <= 1'b1;
              press_time <= now_ms;
              next_rep   <= now_ms + {{(TIME_W-DELAY_W){1'b0}}, cfg.first_delay_ms};
            end else if (due && no_accel) begin
              emit     <= 1'b1;
              next_rep <= now_ms + {{(TIME_W-DELAY_W){1'b0}}, cfg.rest_delay_ms};
            end else begin
              emit <= 1'b0;
            end
          end
        end
        L_MUL: cnt <= '0;
        L_DIV: cnt <= cnt + 1'b1;
        L_FIN: begin
          emit     <= 1'b1;
          next_rep <= now_ms + {{(TIME_W-DELAY_W){1'b0}}, gap};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      L_IDLE: begin
        if (cmd.start) begin
          prog_q <= prog;
          diff_q <= cfg.rest_delay_ms - cfg.min_delay_ms;
          if (!active) begin
            kind <= KIND_RELEASE;
          end else if (!held) begin
            kind <= KIND_PRESS;
          end else begin
            kind <= KIND_REPEAT;
          end
        end
      end
      L_MUL: begin
        dvd <= {{(DIV_STEPS-DELAY_W){1'b0}}, prog_q} *
               {{(DIV_STEPS-DELAY_W){1'b0}}, diff_q};
        rem <= '0;
      end
      L_DIV: begin
        dvd <= {dvd[DIV_STEPS-2:0], ge};
        rem <= ge ? (shifted - {1'b0, cfg.accel_time_ms}) : shifted;
      end
      default: ;
    endcase
  end

  // The scaled step never exceeds rest minus min, so the quotient fits.
  assert property (@(posedge clk) disable iff (rst)
    (state == L_FIN) |-> (dvd[DIV_STEPS-1:DELAY_W] == '0))
    else $error("lane quotient overflowed the delay width");

  assert property (@(posedge clk) disable iff (rst)
    (state == L_IDLE && cmd.start && !active) |=> !held)
    else $error("inactive direction left held");

  assert property (@(posedge clk) disable iff (rst)
    (state == L_MUL) |-> (held && kind == KIND_REPEAT))
    else $error("divider started for a direction that is not repeating");

endmodule

/* rtl/akar_merge.sv */
module akar_merge #(
  parameter int NUM_DIRECTIONS = akar_pkg::NUM_DIRECTIONS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  akar_pkg::lane_stat_t stat [NUM_DIRECTIONS],
  input  logic                 out_ready,
  output logic                 out_valid,
  output akar_pkg::out_item_t  out_item,
  output logic                 busy
);
  import akar_pkg::*;

  logic [NUM_DIRECTIONS-1:0] pend;
  event_kind_t               kinds [NUM_DIRECTIONS];

  logic [NUM_DIRECTIONS-1:0] pend_rest;
  logic                      found;
  logic [1:0]                pick_dir;
  event_kind_t               pick_kind;
  logic                      pick_last;
  logic                      fire;

  // Lowest pending direction goes first.
  always_comb begin
    found     = 1'b0;
    pick_dir  = '0;
    pick_kind = KIND_RELEASE;
    pend_rest = pend;
    for (int i = 0; i < NUM_DIRECTIONS; i++) begin
      if (pend[i] && !found) begin
        found        = 1'b1;
        pick_dir     = 2'(i);
        pick_kind    = kinds[i];
        pend_rest[i] = 1'b0;
      end
    end
  end

  assign pick_last = (pend_rest == '0);
  assign fire      = found && (!out_valid || out_ready);
  assign busy      = (pend != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        for (int i = 0; i < NUM_DIRECTIONS; i++) begin
          pend[i] <= stat[i].emit;
        end
      end else if (fire) begin
        pend <= pend_rest;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < NUM_DIRECTIONS; i++) begin
        kinds[i] <= stat[i].kind;
      end
    end
    if (fire) begin
      out_item.direction  <= pick_dir;
      out_item.event_kind <= pick_kind;
      out_item.last_event <= pick_last;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    load |-> (pend == '0))
    else $error("new results captured before the previous item drained");

  assert property (@(posedge clk) disable iff (rst)
    (fire && pick_last) |=> (pend == '0))
    else $error("results left pending after the last one was sent");

endmodule

/* rtl/accelerating_key_auto_repeat_core.sv */
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+------------------------------------
// in       | input     | in_valid / in_ready  | in_item: now_ms, active_mask
// out      | output    | out_valid / out_ready| out_item: direction, event_kind,
//          |           |                      |           last_event
// cfg      | input     | cfg_we (no wait)     | cfg_index, cfg_data
//
// The block takes a new item only once every lane has finished the last one and
// the merger has handed all its results to the output register. When any
// direction has a repeat whose gap must be scaled, each lane runs its own
// 32-step restoring divider, one quotient bit per cycle. Reset is synchronous,
// clears all direction state and loads the default delays. A stalled output holds
// its item in the output register while the remaining results wait in the merger.
module accelerating_key_auto_repeat_core #(
  parameter int NUM_DIRECTIONS = akar_pkg::NUM_DIRECTIONS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  akar_pkg::in_item_t                   in_item,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output akar_pkg::out_item_t                  out_item,
  input  logic                                 cfg_we,
  input  logic [akar_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [akar_pkg::DELAY_W-1:0]         cfg_data
);
  import akar_pkg::*;

  top_state_t state, state_next;

  // The configuration registers. The user must change them only while the block is idle,
  // as the lanes read them directly throughout an item; the block does not enforce this.
  cfg_t cfg;

  // The item under work is held here until every lane has finished with it.
  in_item_t item;

  lane_cmd_t  cmd;
  lane_stat_t stat [NUM_DIRECTIONS];
  logic [NUM_DIRECTIONS-1:0] done_vec;
  logic all_done;
  logic capture;
  logic busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_delay_ms <= FIRST_DELAY_RST;
      cfg.rest_delay_ms  <= REST_DELAY_RST;
      cfg.min_delay_ms   <= MIN_DELAY_RST;
      cfg.accel_time_ms  <= ACCEL_TIME_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FIRST_DELAY: cfg.first_delay_ms <= cfg_data;
        REG_REST_DELAY:  cfg.rest_delay_ms  <= cfg_data;
        REG_MIN_DELAY:   cfg.min_delay_ms   <= cfg_data;
        REG_ACCEL_TIME:  cfg.accel_time_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

  // One lane per direction. Lanes beyond the width of the mask never see an
  // active direction, so they never hold and never report anything.
  for (genvar d = 0; d < NUM_DIRECTIONS; d++) begin : g_lane
    logic lane_active;
    if (d < MASK_W) begin : g_mask
      assign lane_active = item.active_mask[d];
    end else begin : g_none
      assign lane_active = 1'b0;
    end

    akar_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .cmd    (cmd),
      .cfg    (cfg),
      .now_ms (item.now_ms),
      .active (lane_active),
      .stat   (stat[d])
    );

    assign done_vec[d] = stat[d].done;
  end

  assign all_done = &done_vec;

  // Next-state logic: take an item, start the lanes, wait for all of them,
  // then let the merging stage send the results in direction order.
  always_comb begin
    state_next = state;
    unique case (state)
      T_IDLE: begin
        if (in_valid) begin
          state_next = T_START;
        end
      end
      T_START: state_next = T_RUN;
      T_RUN: begin
        if (all_done) begin
          state_next = T_EMIT;
        end
      end
      T_EMIT: begin
        if (!busy) begin
          state_next = T_IDLE;
        end
      end
      default: state_next = T_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == T_IDLE);
    cmd.start = (state == T_START);
    cmd.ack   = (state == T_RUN) && all_done;
    capture   = (state == T_RUN) && all_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
    end else begin
      state <= state_next;
    end
  end

  akar_merge #(
    .NUM_DIRECTIONS (NUM_DIRECTIONS)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .load      (capture),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item),
    .busy      (busy)
  );

  // While waiting for an item no lane may still be holding a finished result.
  assert property (@(posedge clk) disable iff (rst)
    (state == T_IDLE) |-> (done_vec == '0))
    else $error("lane finished outside an item");

  // The merging stage must be empty by the time lanes are started again.
  assert property (@(posedge clk) disable iff (rst)
    (state == T_START) |-> !busy)
    else $error("lanes started while results were still pending");

endmodule

/* verif/accelerating_key_auto_repeat_core_tb.sv */
`timescale 1ns / 1ps

module accelerating_key_auto_repeat_core_tb;
  import akar_pkg::*;

  // Half of the 12 ns clock period.
  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 12;
  // Quiet time after the last owed event, long enough for an item with no
  // events to finish before the registers are touched.
  localparam int SETTLE_CYCLES = 64;
  // Length of the long receiver hold-off that backs the block up.
  localparam int LONG_HOLD_CYCLES = 500;
  localparam int PHASE_ITEMS = 26;
  localparam int NUM_DIRS = NUM_DIRECTIONS_DEF;

  // Keeps a copy of the per-direction hold state and the delay registers,
  // works out the events that each accepted tick causes and checks the
  // events leaving the block against them in order.
  class key_event_board;
    logic [31:0] first_delay;
    logic [31:0] rest_delay;
    logic [31:0] floor_gap;
    logic [31:0] accel_span;
    logic        held [NUM_DIRS];
    logic [31:0] press_time [NUM_DIRS];
    logic [31:0] next_due [NUM_DIRS];
    out_item_t   pending_events [$];
    int          mismatches;

    function new();
      first_delay = {16'd0, FIRST_DELAY_RST};
      rest_delay  = {16'd0, REST_DELAY_RST};
      floor_gap   = {16'd0, MIN_DELAY_RST};
      accel_span  = {16'd0, ACCEL_TIME_RST};
      for (int d = 0; d < NUM_DIRS; d++) begin
        held[d]       = 1'b0;
        press_time[d] = '0;
        next_due[d]   = '0;
      end
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [DELAY_W-1:0] val);
      case (idx)
        REG_FIRST_DELAY: first_delay = {16'd0, val};
        REG_REST_DELAY:  rest_delay  = {16'd0, val};
        REG_MIN_DELAY:   floor_gap   = {16'd0, val};
        REG_ACCEL_TIME:  accel_span  = {16'd0, val};
        default: ;
      endcase
    endfunction

    // Gap to the following repeat. It falls linearly from the rest delay to the minimum delay over
    // the acceleration span, truncating the division, unless the span is zero or rest <= minimum.
    function logic [31:0] repeat_gap(logic [31:0] now, logic [31:0] start);
      logic [31:0] gap;
      logic [31:0] hold_len;
      logic [31:0] progress;
      gap = rest_delay;
      if (accel_span != 0 && gap > floor_gap) begin
        hold_len = now - start;
        progress = (hold_len < accel_span) ? hold_len : accel_span;
        gap = gap - ((gap - floor_gap) * progress) / accel_span;
      end
      return gap;
    endfunction

    function void note_tick(in_item_t tk);
      out_item_t   ev;
      out_item_t   tick_events [$];
      logic        active;
      logic        emit;
      event_kind_t kind;
      for (int d = 0; d < NUM_DIRS; d++) begin
        active = (d < MASK_W) && tk.active_mask[d];
        emit = 1'b0;
        kind = KIND_RELEASE;
        if (active) begin
          if (!held[d]) begin
            held[d]       = 1'b1;
            press_time[d] = tk.now_ms;
            next_due[d]   = tk.now_ms + first_delay;
            kind = KIND_PRESS;
            emit = 1'b1;
          end else if (tk.now_ms >= next_due[d]) begin
            next_due[d] = tk.now_ms + repeat_gap(tk.now_ms, press_time[d]);
            kind = KIND_REPEAT;
            emit = 1'b1;
          end
        end else begin
          // Letting go of a direction that was never held gives nothing.
          emit          = held[d];
          held[d]       = 1'b0;
          press_time[d] = '0;
          next_due[d]   = '0;
        end
        if (emit && tick_events.size() < 4) begin
          ev.direction  = d[1:0];
          ev.event_kind = kind;
          ev.last_event = 1'b0;
          tick_events.push_back(ev);
        end
      end
      if (tick_events.size() > 0)
        tick_events[tick_events.size() - 1].last_event = 1'b1;
      foreach (tick_events[i]) pending_events.push_back(tick_events[i]);
    endfunction

    function void flag_mismatch(string want_txt, out_item_t got);
      if (mismatches < 10)
        $display("event mismatch: expected %s, got dir %0d kind %0d last %0d",
                 want_txt, got.direction, got.event_kind, got.last_event);
      mismatches++;
    endfunction

    function void check_event(out_item_t got);
      out_item_t want;
      if (pending_events.size() == 0) begin
        flag_mismatch("no event", got);
        return;
      end
      want = pending_events.pop_front();
      if (got.direction !== want.direction || got.event_kind !== want.event_kind ||
          got.last_event !== want.last_event)
        flag_mismatch($sformatf("dir %0d kind %0d last %0d", want.direction,
                                want.event_kind, want.last_event), got);
    endfunction
  endclass

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  in_item_t               in_item   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_item;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [DELAY_W-1:0]     cfg_data  = '0;

  key_event_board board = new();

  // Chances, in per cent, that the sender idles or the receiver stalls in a
  // given cycle. Both are set by the main sequence at the start of a phase.
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;

  // Long hold-off requests: the main sequence bumps the request count and
  // the receiver serves it by counting the stretch down on its own.
  int hold_asked = 0;
  int hold_given = 0;
  int hold_left  = 0;

  // Running tick time and mask of the well-formed tick sequences.
  logic [31:0]       clock_ms = '0;
  logic [MASK_W-1:0] cur_mask = '0;

  accelerating_key_auto_repeat_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  // A hard stop, several times the length of the slowest correct run.
  initial begin
    #6_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Receiver: stalls at random, or for a long stretch when asked, so that
  // the merging stage fills up and the block has to refuse new ticks.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_asked != hold_given) begin
      hold_given = hold_asked;
      hold_left  = LONG_HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Every event taken from the block is checked against the oldest one owed.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_event(out_item);
  end

  function automatic in_item_t tick(logic [31:0] now, logic [MASK_W-1:0] mask);
    in_item_t tk;
    tk.now_ms      = now;
    tk.active_mask = mask;
    return tk;
  endfunction

  // Most ticks follow a steadily advancing clock with a mask that changes
  // only now and then, so that holds last long enough to repeat and to
  // accelerate. The rest are noise with a random time and mask, and the odd
  // jump of the running clock, which also exercises wrap-around.
  function automatic in_item_t random_tick();
    int roll;
    roll = $urandom_range(99);
    if (roll < 12) return tick($urandom(), 4'($urandom_range(15)));
    if (roll < 16) clock_ms = $urandom();
    else clock_ms = clock_ms + $urandom_range(80);
    if ($urandom_range(99) < 25) cur_mask[$urandom_range(MASK_W - 1)] ^= 1'b1;
    return tick(clock_ms, cur_mask);
  endfunction

  // Offers one tick, possibly after a random idle gap, and waits until the
  // block takes it. Called at a rising edge; returns at the accepting edge.
  task automatic send_tick(input in_item_t tk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= tk;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_tick(tk);
  endtask

  // Waits until every owed event has come out, then lets the block finish
  // any tick that caused no events.
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The write enable is left high here so that back-to-back writes never
  // lower and raise it within one step.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [DELAY_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    board.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [DELAY_W-1:0] first, rest, min_gap, accel);
    write_reg(REG_FIRST_DELAY, first);
    write_reg(REG_REST_DELAY, rest);
    write_reg(REG_MIN_DELAY, min_gap);
    write_reg(REG_ACCEL_TIME, accel);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [DELAY_W-1:0] first, rest, min_gap, accel,
                           input int tx_pct, input int rx_pct, input bit long_hold);
    settle();
    apply_settings(first, rest, min_gap, accel);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    clock_ms = $urandom();
    if (long_hold) hold_asked = hold_asked + 1;
    repeat (PHASE_ITEMS) send_tick(random_tick());
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed ticks under the reset delays (420 / 210 / 50 / 1500).
    // Releasing directions that were never held gives nothing.
    send_tick(tick(32'd0, 4'h0));
    // All four pressed together, then just short of and exactly at the
    // first repeat, then well past the acceleration span.
    send_tick(tick(32'd0, 4'hF));
    send_tick(tick(32'd419, 4'hF));
    send_tick(tick(32'd420, 4'hF));
    send_tick(tick(32'd2000, 4'hF));
    send_tick(tick(32'd2000, 4'h0));
    // A press near the top of the clock: its due time wraps to a small
    // value, so the plain compare fires a repeat at once.
    send_tick(tick(32'hFFFF_FF00, 4'h1));
    send_tick(tick(32'hFFFF_FFFF, 4'h1));
    send_tick(tick(32'd0, 4'h1));
    // Mixed presses and releases within one tick.
    send_tick(tick(32'h10, 4'hA));
    send_tick(tick(32'h10, 4'h5));
    send_tick(tick(32'd5000, 4'h5));
    // Time running backwards leaves the held directions quiet.
    send_tick(tick(32'd100, 4'h5));
    send_tick(tick(32'hFFFF_FFFF, 4'hF));
    send_tick(tick(32'd0, 4'h0));

    // Random phases over several register settings and idling patterns.
    run_phase(FIRST_DELAY_RST, REST_DELAY_RST, MIN_DELAY_RST, ACCEL_TIME_RST,
              0, 0, 1'b0);
    run_phase(16'd0, 16'd0, 16'd0, 16'd0, 79, 0, 1'b0);
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 79, 1'b0);
    run_phase(16'd30, 16'd400, 16'd10, 16'd300, 28, 28, 1'b0);
    // Rest delay at or below the minimum: no acceleration at all.
    run_phase(16'd100, 16'd20, 16'd60, 16'd500, 79, 0, 1'b0);
    // Acceleration switched off with a zero span.
    run_phase(16'd50, 16'd80, 16'd5, 16'd0, 0, 79, 1'b0);
    run_phase(16'($urandom_range(200)), 16'($urandom_range(300)),
              16'($urandom_range(100)), 16'($urandom_range(2000)), 28, 28, 1'b0);
    // Widest gap scaling, with the receiver holding off for a long stretch
    // while ticks keep coming.
    run_phase(16'd10, 16'hFFFF, 16'd0, 16'hFFFF, 0, 0, 1'b1);
    run_phase(16'd5, 16'd120, 16'd1, 16'd700, 0, 0, 1'b0);
    run_phase(16'($urandom_range(100)), 16'($urandom_range(250)),
              16'($urandom_range(60)), 16'($urandom_range(1000)), 28, 28, 1'b0);

    settle();
    if (board.mismatches == 0 && board.pending_events.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
